>>> design/image_fnv1a_block_hash_core_macros.svh
// Assertion macros shared by the image hash core.
`ifndef IMAGE_FNV1A_BLOCK_HASH_CORE_MACROS_SVH
`define IMAGE_FNV1A_BLOCK_HASH_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FHASH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FHASH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/fhash_pkg.sv
// Shared types and constants of the image hash core.
package fhash_pkg;

	localparam logic [63:0] FNV_BASIS       = 64'hCBF29CE484222325;
	// The FNV prime is 2^40 + 0x1B3.
	localparam int unsigned FNV_PRIME_SHIFT = 40;
	localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;
	localparam logic [63:0] FMIX_K1         = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] FMIX_K2         = 64'hC4CEB9FE1A85EC53;
	localparam int unsigned FMIX_SHIFT      = 33;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [3:0]  HDR_BYTES   = 4'd10;
	localparam int unsigned TDATA_W     = 120;

	typedef enum logic [1:0] {
		CMD_HDR,
		CMD_ZERO,
		CMD_PIX
	} fhash_kind_t;

	// One input item after unpacking.
	typedef struct packed {
		logic        mode;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  channels;
		logic [7:0]  format;
		logic [63:0] pixel_data;
		logic [3:0]  valid_bytes;
		logic        last_word;
	} fhash_item_t;

	// One queued command for the mixing engine.
	typedef struct packed {
		fhash_kind_t kind;
		logic [79:0] data;
		logic [3:0]  count;
		logic        whole;
		logic        last;
	} fhash_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_XS,
		ST_MUL,
		ST_OUT
	} fhash_state_t;

endpackage

>>> design/image_fnv1a_block_hash_core.sv
// Top level of the streaming FNV-1a image hash core with fmix64 finish.
//
// Use: the slave stream carries one transaction per header or pixel word. tuser
// is the mode (0 header, 1 pixel word), tlast marks the final pixel word, and
// tdata carries the header and pixel fields. A valid header opens an image and
// gives no result; a header whose width, height or channels is zero gives a
// hash of 0 as one master transaction. Pixel words of an open image are folded
// in, and the word with tlast gives the finished hash on the master stream.
// Pixel words outside an open image are taken and dropped.
// Throughput is set by the mixing engine, which performs one FNV multiply per
// cycle: it folds a header byte by byte, a full word at once and a short word
// byte by byte, and runs the fmix64 finish after the last word. It takes the
// next command from the queue only once it is through with the current one.
// A command queue of QUEUE_DEPTH entries lets the front end keep accepting
// transactions while the engine works or while a result waits in the output
// register. When the receiver stalls, the result holds, the engine stops at
// its next result and the queue fills before tready falls.
// After reset no image is open, the queue is empty and no result is pending.
`include "image_fnv1a_block_hash_core_macros.svh"

module image_fnv1a_block_hash_core #(
	parameter int unsigned QUEUE_DEPTH = fhash_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// Fields from bit 0 up: width[15:0], height[15:0], channels[7:0],
	// format[7:0], pixel_data[63:0], valid_bytes[3:0], then four zero bits.
	input  logic [fhash_pkg::TDATA_W-1:0] s_tdata,
	// Fields from bit 0 up: mode.
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Fields from bit 0 up: hash[63:0].
	output logic [63:0]                   m_tdata
);
	import fhash_pkg::*;

	fhash_item_t item;
	fhash_cmd_t  push_cmd;
	fhash_cmd_t  pop_cmd;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	logic        bad_hdr;
	logic        zero_push;

	// Unpack the slave transaction into its fields.
	assign item.mode        = s_tuser;
	assign item.width       = s_tdata[15:0];
	assign item.height      = s_tdata[31:16];
	assign item.channels    = s_tdata[39:32];
	assign item.format      = s_tdata[47:40];
	assign item.pixel_data  = s_tdata[111:48];
	assign item.valid_bytes = s_tdata[115:112];
	assign item.last_word   = s_tlast;

	fhash_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.item     (item),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	fhash_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	fhash_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.cmd       (pop_cmd),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hash  (m_tdata)
	);

	// A header transaction with zero width, and a zero-hash command being queued.
	assign bad_hdr   = s_tvalid && s_tready && !s_tuser && (s_tdata[15:0] == 16'd0);
	assign zero_push = push && (push_cmd.kind == CMD_ZERO);

	// The queue is never written while full, nor read while empty.
	`FHASH_ASSERT_NOW(a_no_push_full, full, !push, "command pushed into a full queue")
	`FHASH_ASSERT_NOW(a_no_pop_empty, empty, !pop, "command popped from an empty queue")
	// A header with zero width must queue a zero-hash command in the same cycle.
	`FHASH_ASSERT_NOW(a_bad_hdr_zero, bad_hdr, zero_push, "zero hash not queued")

endmodule

>>> design/fhash_front.sv
// Front end: accepts items, tracks whether an image is open and queues commands.
module fhash_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  fhash_pkg::fhash_item_t item,
	output logic                   push,
	output fhash_pkg::fhash_cmd_t  push_cmd,
	input  logic                   full
);
	import fhash_pkg::*;

	logic open_q;
	logic accept;
	logic hdr_ok;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign hdr_ok   = (item.width != 16'd0) && (item.height != 16'd0) &&
		(item.channels != 8'd0);

	always_comb begin
		push          = 1'b0;
		push_cmd.kind = CMD_PIX;
		push_cmd.data = {16'd0, item.pixel_data};
		push_cmd.count = item.valid_bytes;
		push_cmd.whole = 1'b0;
		push_cmd.last  = item.last_word;
		if (!item.mode) begin
			push           = accept;
			push_cmd.kind  = hdr_ok ? CMD_HDR : CMD_ZERO;
			// Header bytes in mixing order: width, height, channels, format.
			push_cmd.data  = {item.format, item.channels, 16'd0, item.height,
				16'd0, item.width};
			push_cmd.count = HDR_BYTES;
			push_cmd.last  = 1'b0;
		end else begin
			// Pixel words of a closed image are dropped here.
			push = accept && open_q;
			if (item.valid_bytes >= 4'd8) begin
				push_cmd.whole = 1'b1;
				push_cmd.count = 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (accept) begin
			if (!item.mode) begin
				open_q <= hdr_ok;
			end else if (item.last_word) begin
				open_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/fhash_fifo.sv
// Short command queue between the front end and the mixing engine.
module fhash_fifo #(
	parameter int unsigned DEPTH = fhash_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fhash_pkg::fhash_cmd_t push_cmd,
	output logic                  full,
	input  logic                  pop,
	output fhash_pkg::fhash_cmd_t pop_cmd,
	output logic                  empty
);
	import fhash_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	fhash_cmd_t      mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/fhash_back.sv
// Mixing engine: FNV-1a byte and word folding, fmix64 finish and result register.
module fhash_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  fhash_pkg::fhash_cmd_t cmd,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           out_hash
);
	import fhash_pkg::*;

	fhash_state_t state_q, state_d;
	logic [63:0]  hash_q;
	logic [79:0]  buf_q;
	logic [3:0]   cnt_q;
	logic         whole_q;
	logic         last_q;
	logic [63:0]  fin_q;
	logic [63:0]  acc_q;
	logic [1:0]   ph_q;
	logic [1:0]   rnd_q;
	logic         out_valid_q;
	logic [63:0]  out_hash_q;

	logic         out_load;
	logic [63:0]  mix_x;
	logic [63:0]  mix_next;
	logic [63:0]  fin_xs;
	logic [63:0]  kconst;
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  mul_p;

	// FNV step: multiply by 2^40 + 0x1B3 as a shift and a narrow product.
	assign mix_x    = hash_q ^ (whole_q ? buf_q[63:0] : {56'd0, buf_q[7:0]});
	assign mix_next = {mix_x[63-FNV_PRIME_SHIFT:0], {FNV_PRIME_SHIFT{1'b0}}} +
		64'(mix_x * FNV_PRIME_LO);

	assign fin_xs = fin_q ^ (fin_q >> FMIX_SHIFT);

	// 64-bit product modulo 2^64 from three 32 by 32 partial products.
	assign kconst = (rnd_q == 2'd0) ? FMIX_K1 : FMIX_K2;
	assign mul_a  = (ph_q == 2'd1) ? fin_q[63:32] : fin_q[31:0];
	assign mul_b  = (ph_q == 2'd2) ? kconst[63:32] : kconst[31:0];
	assign mul_p  = mul_a * mul_b;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					state_d = (cmd.kind == CMD_ZERO) ? ST_OUT : ST_MIX;
				end
			end
			ST_MIX: begin
				if (cnt_q == 4'd0) begin
					state_d = last_q ? ST_XS : ST_IDLE;
				end
			end
			ST_XS: begin
				state_d = (rnd_q == 2'd2) ? ST_OUT : ST_MUL;
			end
			ST_MUL: begin
				if (ph_q == 2'd2) begin
					state_d = ST_XS;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = !empty;
			end
			ST_OUT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				pop      = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= '0;
			rnd_q       <= '0;
			cnt_q       <= '0;
			whole_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				cnt_q   <= cmd.count;
				whole_q <= cmd.whole;
				last_q  <= cmd.last;
				rnd_q   <= '0;
			end
			if (state_q == ST_MIX && cnt_q != 4'd0) begin
				cnt_q <= cnt_q - 4'd1;
			end
			if (state_q == ST_XS) begin
				ph_q <= '0;
			end
			if (state_q == ST_MUL) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd2) begin
					rnd_q <= rnd_q + 2'd1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			buf_q <= cmd.data;
			if (cmd.kind == CMD_HDR) begin
				hash_q <= FNV_BASIS;
			end
			if (cmd.kind == CMD_ZERO) begin
				fin_q <= '0;
			end
		end
		case (state_q)
			ST_MIX: begin
				if (cnt_q != 4'd0) begin
					hash_q <= mix_next;
					buf_q  <= buf_q >> 8;
				end else begin
					fin_q <= hash_q;
				end
			end
			ST_XS: begin
				fin_q <= fin_xs;
			end
			ST_MUL: begin
				case (ph_q)
					2'd0: acc_q <= mul_p;
					2'd1: acc_q <= acc_q + {mul_p[31:0], 32'd0};
					default: fin_q <= acc_q + {mul_p[31:0], 32'd0};
				endcase
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_hash_q <= fin_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hash  = out_hash_q;

endmodule

>>> tb/sv/fhash_tb_pkg.sv
// Item kinds and word size shared by the image hash testbench and its checker.
package fhash_tb_pkg;

	typedef enum logic {
		MODE_HEADER = 1'b0,
		MODE_PIXEL  = 1'b1
	} item_mode_t;

	localparam int unsigned WORD_BYTES = 8;

endpackage

>>> tb/sv/image_hash_checker.sv
// Checker that predicts image hashes from the slave stream and compares the master stream.
module image_hash_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [fhash_pkg::TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [63:0]                   m_tdata,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import fhash_pkg::*;
	import fhash_tb_pkg::*;

	localparam logic [63:0] PRIME = (64'd1 << FNV_PRIME_SHIFT) | 64'(FNV_PRIME_LO);
	localparam int          SHOWN = 10;

	logic [63:0] run_hash;
	logic        img_open;
	logic [63:0] hash_due[$];
	int          fail_cnt;

	function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
		return (h ^ {56'd0, b}) * PRIME;
	endfunction

	function automatic logic [63:0] fmix64(input logic [63:0] h);
		logic [63:0] x;
		x = h ^ (h >> FMIX_SHIFT);
		x = x * FMIX_K1;
		x = x ^ (x >> FMIX_SHIFT);
		x = x * FMIX_K2;
		return x ^ (x >> FMIX_SHIFT);
	endfunction

	// The header is mixed as ten bytes: width and height as four little-endian
	// bytes each (upper halves zero), then channels and format.
	function automatic logic [63:0] header_hash(input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] ch, input logic [7:0] fmt);
		logic [79:0] seq;
		logic [63:0] acc;
		seq = {fmt, ch, 16'd0, h, 16'd0, w};
		acc = FNV_BASIS;
		for (int k = 0; k < 10; k++)
			acc = fnv_byte(acc, seq[8*k +: 8]);
		return acc;
	endfunction

	function automatic void note_fail(input string what);
		fail_cnt++;
		if (fail_cnt <= SHOWN)
			$display("[%0t] image_hash_checker: %s", $realtime, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [15:0] w;
		logic [15:0] ht;
		logic [7:0]  ch;
		logic [7:0]  fmt;
		logic [63:0] pix;
		logic [3:0]  nb;
		logic [63:0] want;
		if (!arst_n) begin
			run_hash = FNV_BASIS;
			img_open = 1'b0;
			hash_due.delete();
			fail_cnt = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// A result cannot leave at the edge its cause arrives, so the
			// master side is checked before the slave side is absorbed.
			if (m_tvalid && m_tready) begin
				if (hash_due.size() == 0) begin
					note_fail($sformatf("result %h with none expected", m_tdata));
				end else begin
					want = hash_due.pop_front();
					if (m_tdata !== want)
						note_fail($sformatf("hash expected %h, got %h", want, m_tdata));
				end
			end

			if (s_tvalid && s_tready) begin
				w   = s_tdata[15:0];
				ht  = s_tdata[31:16];
				ch  = s_tdata[39:32];
				fmt = s_tdata[47:40];
				pix = s_tdata[111:48];
				nb  = s_tdata[115:112];
				if (s_tuser == MODE_HEADER) begin
					run_hash = header_hash(w, ht, ch, fmt);
					img_open = (w != 16'd0) && (ht != 16'd0) && (ch != 8'd0);
					if (!img_open)
						hash_due.push_back(64'd0);
				end else if (img_open) begin
					// Eight or more valid bytes fold the whole word at once;
					// a short word folds byte by byte from the bottom.
					if (nb >= WORD_BYTES) begin
						run_hash = (run_hash ^ pix) * PRIME;
					end else begin
						for (int k = 0; k < int'(nb); k++)
							run_hash = fnv_byte(run_hash, pix[8*k +: 8]);
					end
					if (s_tlast) begin
						hash_due.push_back(fmix64(run_hash));
						img_open = 1'b0;
					end
				end
			end

			errors  <= fail_cnt;
			pending <= hash_due.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the image hash testbench: clock, reset, stimulus and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fhash_pkg::*;
	import fhash_tb_pkg::*;

	// Number of counted transactions in the random part of the run.
	localparam int RANDOM_ITEMS = 1350;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               s_tuser  = 1'b0;
	logic               s_tlast  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [63:0]        m_tdata;

	// While calm is set neither side idles; it is written with nonblocking
	// assignments so that both sides see the same value at each edge.
	logic               calm     = 1'b0;

	int                 errors;
	int                 pending;

	image_fnv1a_block_hash_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	image_hash_checker scoreboard (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver stalls in roughly one cycle out of ten, except during the
	// calm stretch, and holds tready low throughout reset.
	always @(posedge clk) begin
		m_tready <= arst_n && (calm || $urandom_range(99) >= 10);
	end

	// Every field is random to begin with, so that fields the item kind
	// ignores still carry arbitrary values.
	function automatic fhash_item_t rand_item();
		fhash_item_t it;
		it.mode        = 1'($urandom_range(1));
		it.width       = 16'($urandom);
		it.height      = 16'($urandom);
		it.channels    = 8'($urandom);
		it.format      = 8'($urandom);
		it.pixel_data  = {$urandom, $urandom};
		it.valid_bytes = 4'($urandom);
		it.last_word   = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic fhash_item_t header(input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] ch, input logic [7:0] fmt);
		fhash_item_t it;
		it          = rand_item();
		it.mode     = MODE_HEADER;
		it.width    = w;
		it.height   = h;
		it.channels = ch;
		it.format   = fmt;
		return it;
	endfunction

	function automatic fhash_item_t pixel(input logic [63:0] data, input logic [3:0] nb,
			input logic last);
		fhash_item_t it;
		it             = rand_item();
		it.mode        = MODE_PIXEL;
		it.pixel_data  = data;
		it.valid_bytes = nb;
		it.last_word   = last;
		return it;
	endfunction

	// Half the dimensions are small, the rest span the whole field.
	function automatic logic [15:0] rand_dim();
		if ($urandom_range(1) == 0)
			return 16'($urandom_range(1, 16));
		return 16'($urandom_range(1, 65535));
	endfunction

	// Mostly whole words and ordinary tails, with the occasional empty word
	// and the occasional count above a whole word.
	function automatic logic [3:0] pick_bytes();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 4'(WORD_BYTES);
		if (r < 88)
			return 4'($urandom_range(1, WORD_BYTES - 1));
		if (r < 94)
			return 4'd0;
		return 4'($urandom_range(WORD_BYTES + 1, 15));
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Presents one transaction after an optional idle gap and returns at the
	// edge where it is accepted. It is always entered just after an edge.
	task automatic send_item(input fhash_item_t it);
		while (!calm && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tlast  <= it.last_word;
		s_tdata  <= {4'd0, it.valid_bytes, it.pixel_data, it.format, it.channels,
			it.height, it.width};
		do @(posedge clk); while (!s_tready);
	endtask

	// Holds the sender off until every predicted hash has been seen.
	task automatic wait_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : stimulus
		fhash_item_t hd;
		int          sent;
		int          words;
		int          pick;
		bit          drained;
		sent    = 0;
		drained = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A pixel word straight after reset has no open image
		// and must be dropped.
		send_item(pixel(rand_word(), 4'(WORD_BYTES), 1'b1));
		// Each of the three zero dimensions gives a hash of 0 at once.
		send_item(header(16'd0, 16'd5, 8'd3, 8'd1));
		send_item(header(16'd7, 16'd0, 8'd3, 8'd1));
		send_item(header(16'd7, 16'd5, 8'd0, 8'hFF));
		// A word after an invalid header is ignored, even with tlast.
		send_item(pixel(rand_word(), 4'd3, 1'b1));
		// Largest header, then every kind of word up to a last word whose
		// count exceeds a whole word.
		send_item(header(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
		send_item(pixel(64'hFFFF_FFFF_FFFF_FFFF, 4'(WORD_BYTES), 1'b0));
		send_item(pixel(rand_word(), 4'd0, 1'b0));
		send_item(pixel(rand_word(), 4'd1, 1'b0));
		send_item(pixel(rand_word(), 4'(WORD_BYTES - 1), 1'b0));
		send_item(pixel(rand_word(), 4'd15, 1'b1));
		// A word after a finished image is ignored.
		send_item(pixel(rand_word(), 4'(WORD_BYTES), 1'b1));
		// Smallest valid image with format 0, finished by an empty last word.
		send_item(header(16'd1, 16'd1, 8'd1, 8'd0));
		send_item(pixel(rand_word(), 4'd0, 1'b1));
		// An all-zero last word with a count just above a whole word.
		send_item(header(16'd1, 16'd1, 8'd1, 8'd9));
		send_item(pixel(64'd0, 4'(WORD_BYTES + 1), 1'b1));
		// A header in the middle of an image starts the hash afresh.
		send_item(header(16'd3, 16'd3, 8'd3, 8'd1));
		send_item(pixel(rand_word(), 4'd4, 1'b0));
		send_item(header(16'd2, 16'd2, 8'd2, 8'd2));
		send_item(pixel(rand_word(), 4'(WORD_BYTES), 1'b1));
		wait_results();

		// Random part: mostly complete images with random content, plus
		// invalid headers, abandoned images and stray words.
		while (sent < RANDOM_ITEMS) begin
			calm <= (sent >= 500 && sent < 760);
			if (!drained && sent >= 650) begin
				wait_results();
				drained = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 78) begin
				words = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
				send_item(header(rand_dim(), rand_dim(), 8'($urandom_range(1, 255)),
					8'($urandom_range(255))));
				for (int k = 1; k <= words; k++)
					send_item(pixel(rand_word(), pick_bytes(), k == words));
				sent += words + 1;
			end else if (pick < 87) begin
				hd = header(rand_dim(), rand_dim(), 8'($urandom_range(1, 255)),
					8'($urandom_range(255)));
				case ($urandom_range(3))
					0: hd.width = 16'd0;
					1: hd.height = 16'd0;
					2: hd.channels = 8'd0;
					default: begin
						hd.width  = 16'd0;
						hd.height = 16'd0;
					end
				endcase
				send_item(hd);
				sent++;
				// Words after an invalid header are only dropped.
				repeat ($urandom_range(2))
					send_item(pixel(rand_word(), pick_bytes(), 1'($urandom_range(1))));
			end else if (pick < 95) begin
				// An image left open; a later header restarts it unless stray words close it first.
				words = $urandom_range(1, 3);
				send_item(header(rand_dim(), rand_dim(), 8'($urandom_range(1, 255)),
					8'($urandom_range(255))));
				for (int k = 0; k < words; k++)
					send_item(pixel(rand_word(), pick_bytes(), 1'b0));
				sent += words + 1;
			end else begin
				// Stray words; if an image is open they fold into it, and one with tlast closes it.
				repeat ($urandom_range(1, 3))
					send_item(pixel(rand_word(), pick_bytes(), 1'($urandom_range(1))));
			end
		end
		calm <= 1'b0;

		// Let the last hash arrive, then allow for the engine's latency so that
		// any spurious late result is still caught.
		wait_results();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Guard against a hang; far beyond the slowest correct run.
	initial begin : watchdog
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/fhash_pkg.sv
design/fhash_front.sv
design/fhash_fifo.sv
design/fhash_back.sv
design/image_fnv1a_block_hash_core.sv
tb/sv/fhash_tb_pkg.sv
tb/sv/image_hash_checker.sv
tb/sv/testbench.sv
